FILE: src/sfrc_pkg.sv
// shared constants, types and tables of the single frequency response correlator
package sfrc_pkg;

  localparam int DEF_SAMPLE_BITS   = 16;
  localparam int DEF_ACC_BITS      = 48;
  localparam int DEF_CORDIC_STAGES = 16;

  // cordic datapath widths (the vectoring input is a 32-bit value shifted up by 16)
  localparam int CW    = 51;
  localparam int ZW    = 34;
  localparam int CNT_W = 7;
  localparam int OP_W  = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [31:0] CORDIC_GAIN_INV = 32'd652032874;

  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_AMP  = 1'd1;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_TZERO = 2'd1;
  localparam logic [1:0] STATUS_SAT  = 2'd2;

  // datapath operations, one per controller state
  localparam logic [OP_W-1:0] OP_IDLE  = 5'd0;
  localparam logic [OP_W-1:0] OP_ANG   = 5'd1;
  localparam logic [OP_W-1:0] OP_RINIT = 5'd2;
  localparam logic [OP_W-1:0] OP_ROT   = 5'd3;
  localparam logic [OP_W-1:0] OP_TRIG  = 5'd4;
  localparam logic [OP_W-1:0] OP_MULS  = 5'd5;
  localparam logic [OP_W-1:0] OP_ACCS  = 5'd6;
  localparam logic [OP_W-1:0] OP_ACCC  = 5'd7;
  localparam logic [OP_W-1:0] OP_DINI  = 5'd8;
  localparam logic [OP_W-1:0] OP_DIVI  = 5'd9;
  localparam logic [OP_W-1:0] OP_DFNI  = 5'd10;
  localparam logic [OP_W-1:0] OP_DINQ  = 5'd11;
  localparam logic [OP_W-1:0] OP_DIVQ  = 5'd12;
  localparam logic [OP_W-1:0] OP_DFNQ  = 5'd13;
  localparam logic [OP_W-1:0] OP_SQI   = 5'd14;
  localparam logic [OP_W-1:0] OP_SQQ   = 5'd15;
  localparam logic [OP_W-1:0] OP_SQRT  = 5'd16;
  localparam logic [OP_W-1:0] OP_GINI  = 5'd17;
  localparam logic [OP_W-1:0] OP_GDIV  = 5'd18;
  localparam logic [OP_W-1:0] OP_GFIN  = 5'd19;
  localparam logic [OP_W-1:0] OP_VINI  = 5'd20;
  localparam logic [OP_W-1:0] OP_VEC   = 5'd21;
  localparam logic [OP_W-1:0] OP_FIN   = 5'd22;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [CNT_W-1:0] iter;
    logic             load;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic t_zero;
    logic out_free;
  } sts_t;

  // dividend width shared by the scaling and gain divisions
  function automatic int div_width(input int acc_bits, input int sample_bits);
    return (acc_bits > sample_bits + 31) ? acc_bits : sample_bits + 31;
  endfunction

  // atan(2^-i) as a turn fraction, 2^32 is a turn
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] a;
    case (idx)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10679838;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41721;
      5'd15: a = 32'd20860;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2607;
      5'd19: a = 32'd1303;
      5'd20: a = 32'd651;
      5'd21: a = 32'd325;
      5'd22: a = 32'd162;
      5'd23: a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

  // round to q1.15 with clamping
  function automatic logic signed [15:0] q15_round(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    logic signed [15:0] q;
    r = (v + CW'(16384)) >>> 15;
    if (r > CW'(32767)) q = 16'sd32767;
    else if (r < -CW'(32768)) q = -16'sd32768;
    else q = r[15:0];
    return q;
  endfunction

endpackage

FILE: src/sfrc_ctrl.sv
// sequencer for the correlator datapath
module sfrc_ctrl #(
  parameter int SAMPLE_BITS   = sfrc_pkg::DEF_SAMPLE_BITS,
  parameter int ACC_BITS      = sfrc_pkg::DEF_ACC_BITS,
  parameter int CORDIC_STAGES = sfrc_pkg::DEF_CORDIC_STAGES
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  sfrc_pkg::sts_t sts,
  output sfrc_pkg::cmd_t cmd
);
  import sfrc_pkg::*;

  localparam int DW = div_width(ACC_BITS, SAMPLE_BITS);

  localparam logic [OP_W-1:0] S_IDLE  = OP_IDLE;
  localparam logic [OP_W-1:0] S_ANG   = OP_ANG;
  localparam logic [OP_W-1:0] S_RINIT = OP_RINIT;
  localparam logic [OP_W-1:0] S_ROT   = OP_ROT;
  localparam logic [OP_W-1:0] S_TRIG  = OP_TRIG;
  localparam logic [OP_W-1:0] S_MULS  = OP_MULS;
  localparam logic [OP_W-1:0] S_ACCS  = OP_ACCS;
  localparam logic [OP_W-1:0] S_ACCC  = OP_ACCC;
  localparam logic [OP_W-1:0] S_DINI  = OP_DINI;
  localparam logic [OP_W-1:0] S_DIVI  = OP_DIVI;
  localparam logic [OP_W-1:0] S_DFNI  = OP_DFNI;
  localparam logic [OP_W-1:0] S_DINQ  = OP_DINQ;
  localparam logic [OP_W-1:0] S_DIVQ  = OP_DIVQ;
  localparam logic [OP_W-1:0] S_DFNQ  = OP_DFNQ;
  localparam logic [OP_W-1:0] S_SQI   = OP_SQI;
  localparam logic [OP_W-1:0] S_SQQ   = OP_SQQ;
  localparam logic [OP_W-1:0] S_SQRT  = OP_SQRT;
  localparam logic [OP_W-1:0] S_GINI  = OP_GINI;
  localparam logic [OP_W-1:0] S_GDIV  = OP_GDIV;
  localparam logic [OP_W-1:0] S_GFIN  = OP_GFIN;
  localparam logic [OP_W-1:0] S_VINI  = OP_VINI;
  localparam logic [OP_W-1:0] S_VEC   = OP_VEC;
  localparam logic [OP_W-1:0] S_FIN   = OP_FIN;

  logic [OP_W-1:0]  state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] lim_m1;
  logic             iterating;
  logic             done;

  always_comb begin
    iterating = 1'b1;
    case (state_r)
      S_ROT, S_VEC:          lim_m1 = CNT_W'(CORDIC_STAGES - 1);
      S_DIVI, S_DIVQ, S_GDIV: lim_m1 = CNT_W'(DW - 1);
      S_SQRT:                lim_m1 = CNT_W'(31);
      default: begin
        lim_m1 = '0;
        iterating = 1'b0;
      end
    endcase
  end

  assign done = (cnt_r == lim_m1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_ANG;
      S_ANG:   state_nxt = S_RINIT;
      S_RINIT: state_nxt = S_ROT;
      S_ROT:   if (done) state_nxt = S_TRIG;
      S_TRIG:  state_nxt = S_MULS;
      S_MULS:  state_nxt = S_ACCS;
      S_ACCS:  state_nxt = S_ACCC;
      S_ACCC: begin
        if (!sts.last) state_nxt = S_IDLE;
        else if (sts.t_zero) state_nxt = S_FIN;
        else state_nxt = S_DINI;
      end
      S_DINI:  state_nxt = S_DIVI;
      S_DIVI:  if (done) state_nxt = S_DFNI;
      S_DFNI:  state_nxt = S_DINQ;
      S_DINQ:  state_nxt = S_DIVQ;
      S_DIVQ:  if (done) state_nxt = S_DFNQ;
      S_DFNQ:  state_nxt = S_SQI;
      S_SQI:   state_nxt = S_SQQ;
      S_SQQ:   state_nxt = S_SQRT;
      S_SQRT:  if (done) state_nxt = S_GINI;
      S_GINI:  state_nxt = S_GDIV;
      S_GDIV:  if (done) state_nxt = S_GFIN;
      S_GFIN:  state_nxt = S_VINI;
      S_VINI:  state_nxt = S_VEC;
      S_VEC:   if (done) state_nxt = S_FIN;
      S_FIN:   if (sts.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign cnt_nxt = (iterating && !done) ? cnt_r + 1'b1 : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign cmd.op   = state_r;
  assign cmd.iter = cnt_r;
  assign cmd.load = (state_r == S_IDLE) && in_valid;

  a_rot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROT) |-> (cnt_r < CNT_W'(CORDIC_STAGES)))
    else $error("cordic iteration count out of range");

  a_plain_item_back: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACCC && !sts.last) |=> (state_r == S_IDLE))
    else $error("non-final item did not return to idle");

  a_fin_release: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && sts.out_free) |=> (state_r == S_IDLE))
    else $error("result commit did not release the sequencer");

endmodule

FILE: src/sfrc_dp.sv
// correlator datapath: phase multiply, shared cordic, accumulators, divider, square root
module sfrc_dp #(
  parameter int SAMPLE_BITS   = sfrc_pkg::DEF_SAMPLE_BITS,
  parameter int ACC_BITS      = sfrc_pkg::DEF_ACC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  sfrc_pkg::cmd_t                       cmd,
  output sfrc_pkg::sts_t                       sts,
  input  logic [31:0]                          in_sample_time,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample_value,
  input  logic                                 in_last,
  input  logic                                 cfg_we,
  input  logic [sfrc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                          cfg_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [31:0]                   out_in_phase_part,
  output logic signed [31:0]                   out_quadrature_part,
  output logic [23:0]                          out_gain,
  output logic signed [15:0]                   out_phase,
  output logic [1:0]                           out_status
);
  import sfrc_pkg::*;

  localparam int DW = div_width(ACC_BITS, SAMPLE_BITS);
  localparam int SH = SAMPLE_BITS - 3;
  localparam int PW = SAMPLE_BITS + 16;
  localparam int SW = ((ACC_BITS > PW) ? ACC_BITS : PW) + 1;

  // configuration
  logic [31:0] phase_step_r;
  logic [15:0] amp_r;

  // item
  logic [31:0]                   t_r;
  logic signed [SAMPLE_BITS-1:0] samp_r;
  logic                          last_r;
  logic [31:0]                   ang_r;

  // cordic
  logic signed [CW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;
  logic                 neg_r;
  logic signed [15:0]   sin_r, cos_r;

  // accumulate
  logic signed [PW-1:0]       prod_r;
  logic signed [ACC_BITS-1:0] ssum_r, csum_r;
  logic                       sat_r;

  // divider, quotient shifts into the dividend register
  logic [DW-1:0] dvd_r;
  logic [31:0]   rem_r, dsr_r;
  logic          dneg_r;

  logic signed [31:0] ip_r, qp_r;
  logic               rsat_r;
  logic [63:0]        sq_r, v_r, r_r;
  logic [23:0]        gain_r;

  logic out_valid_r;
  logic signed [31:0] out_ip_r, out_qp_r;
  logic [23:0]        out_gain_r;
  logic signed [15:0] out_ph_r;
  logic [1:0]         out_status_r;

  // cordic step
  logic signed [CW-1:0] xs, ys, x_step, y_step, xf, yf;
  logic signed [ZW-1:0] at, z_step;
  logic                 dsub;

  always_comb begin
    xs = x_r >>> cmd.iter;
    ys = y_r >>> cmd.iter;
    at = ZW'(atan_turn(cmd.iter[4:0]));
    dsub = (cmd.op == OP_ROT) ? !z_r[ZW-1] : y_r[CW-1];
    x_step = dsub ? x_r - ys : x_r + ys;
    y_step = dsub ? y_r + xs : y_r - xs;
    z_step = dsub ? z_r - at : z_r + at;
    xf = neg_r ? -x_r : x_r;
    yf = neg_r ? -y_r : y_r;
  end

  // rotation start: fold the two middle quadrants by half a turn
  logic        rneg;
  logic [31:0] ang_f;
  assign rneg  = ang_r[31] ^ ang_r[30];
  assign ang_f = {ang_r[31] ^ rneg, ang_r[30:0]};

  // multiply and saturating accumulate
  logic signed [15:0]         trig_sel;
  logic signed [PW-1:0]       prod;
  logic signed [ACC_BITS-1:0] acc_sel, acc_sat;
  logic signed [SW-1:0]       sum_w;
  logic                       ovf;

  assign trig_sel = (cmd.op == OP_MULS) ? sin_r : cos_r;
  assign prod     = samp_r * trig_sel;
  assign acc_sel  = (cmd.op == OP_ACCS) ? ssum_r : csum_r;

  always_comb begin
    sum_w = SW'(acc_sel) + SW'(prod_r);
    ovf = (sum_w[SW-1:ACC_BITS-1] != '0) && (sum_w[SW-1:ACC_BITS-1] != '1);
    if (!ovf) acc_sat = sum_w[ACC_BITS-1:0];
    else if (sum_w[SW-1]) acc_sat = {1'b1, {(ACC_BITS-1){1'b0}}};
    else acc_sat = {1'b0, {(ACC_BITS-1){1'b1}}};
  end

  // division step and scaling
  logic [32:0]                rem_sh, rem_diff;
  logic                       ge;
  logic signed [ACC_BITS-1:0] dsrc;
  logic [ACC_BITS-1:0]        dmag;
  logic                       qsat;
  logic signed [31:0]         qval;

  always_comb begin
    rem_sh   = {rem_r, dvd_r[DW-1]};
    rem_diff = rem_sh - {1'b0, dsr_r};
    ge       = (rem_sh >= {1'b0, dsr_r});
    dsrc     = (cmd.op == OP_DINI) ? ssum_r : csum_r;
    dmag     = dsrc[ACC_BITS-1] ? ACC_BITS'(-dsrc) : ACC_BITS'(dsrc);
    if (dneg_r) begin
      qsat = (|dvd_r[DW-1:32]) || (dvd_r[31] && (|dvd_r[30:0]));
      qval = qsat ? 32'sh80000000 : -$signed(dvd_r[31:0]);
    end else begin
      qsat = |dvd_r[DW-1:31];
      qval = qsat ? 32'sh7fffffff : $signed(dvd_r[31:0]);
    end
  end

  // squares and root step
  logic signed [63:0] ipsq, qpsq;
  logic [63:0]        sbit, rb;
  assign ipsq = ip_r * ip_r;
  assign qpsq = qp_r * qp_r;
  assign sbit = 64'd1 << (CNT_W'(62) - (cmd.iter << 1));
  assign rb   = r_r + sbit;

  logic        out_free;
  logic        zero_vec;
  logic [31:0] z_rnd;
  assign out_free = !out_valid_r || !out_stall;
  assign zero_vec = (ip_r == '0) && (qp_r == '0);
  assign z_rnd    = z_r[31:0] + 32'h8000;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= '0;
      amp_r        <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PHASE_STEP: phase_step_r <= cfg_data;
        CFG_DRIVE_AMP:  amp_r        <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ssum_r      <= '0;
      csum_r      <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_ACCS) begin
        ssum_r <= acc_sat;
        if (ovf) sat_r <= 1'b1;
      end else if (cmd.op == OP_ACCC) begin
        csum_r <= acc_sat;
        if (ovf) sat_r <= 1'b1;
      end else if (cmd.op == OP_FIN && out_free) begin
        ssum_r <= '0;
        csum_r <= '0;
        sat_r  <= 1'b0;
      end
      if (cmd.op == OP_FIN && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_r    <= in_sample_time;
      samp_r <= in_sample_value;
      last_r <= in_last;
    end
    case (cmd.op)
      OP_ANG: ang_r <= 32'(phase_step_r * t_r);
      OP_RINIT: begin
        x_r   <= CW'(CORDIC_GAIN_INV);
        y_r   <= '0;
        z_r   <= ZW'($signed(ang_f));
        neg_r <= rneg;
      end
      OP_ROT, OP_VEC: begin
        x_r <= x_step;
        y_r <= y_step;
        z_r <= z_step;
      end
      OP_TRIG: begin
        sin_r <= q15_round(yf);
        cos_r <= q15_round(xf);
      end
      OP_MULS, OP_ACCS: prod_r <= prod;
      OP_DINI, OP_DINQ: begin
        dvd_r  <= DW'(dmag >> SH);
        rem_r  <= '0;
        dsr_r  <= t_r;
        dneg_r <= dsrc[ACC_BITS-1];
      end
      OP_DIVI, OP_DIVQ, OP_GDIV: begin
        rem_r <= ge ? rem_diff[31:0] : rem_sh[31:0];
        dvd_r <= {dvd_r[DW-2:0], ge};
      end
      OP_DFNI: begin
        ip_r   <= qval;
        rsat_r <= sat_r | qsat;
      end
      OP_DFNQ: begin
        qp_r   <= qval;
        rsat_r <= rsat_r | qsat;
      end
      OP_SQI: sq_r <= ipsq;
      OP_SQQ: begin
        v_r <= sq_r + qpsq;
        r_r <= '0;
      end
      OP_SQRT: begin
        if (v_r >= rb) begin
          v_r <= v_r - rb;
          r_r <= (r_r >> 1) + sbit;
        end else begin
          r_r <= r_r >> 1;
        end
      end
      OP_GINI: begin
        dvd_r <= DW'(r_r[31:0]) << (SAMPLE_BITS - 1);
        rem_r <= '0;
        dsr_r <= 32'(amp_r);
      end
      OP_GFIN: begin
        if (amp_r == '0 || (|dvd_r[DW-1:24])) gain_r <= '1;
        else gain_r <= dvd_r[23:0];
      end
      OP_VINI: begin
        if (ip_r[31]) begin
          x_r <= -(CW'(ip_r) <<< 16);
          y_r <= -(CW'(qp_r) <<< 16);
          z_r <= ZW'(32'h80000000);
        end else begin
          x_r <= CW'(ip_r) <<< 16;
          y_r <= CW'(qp_r) <<< 16;
          z_r <= '0;
        end
      end
      OP_FIN: begin
        if (out_free) begin
          if (t_r == '0) begin
            out_ip_r     <= '0;
            out_qp_r     <= '0;
            out_gain_r   <= '0;
            out_ph_r     <= '0;
            out_status_r <= STATUS_TZERO;
          end else begin
            out_ip_r     <= ip_r;
            out_qp_r     <= qp_r;
            out_gain_r   <= gain_r;
            out_ph_r     <= zero_vec ? 16'sd0 : $signed(z_rnd[31:16]);
            out_status_r <= rsat_r ? STATUS_SAT : STATUS_OK;
          end
        end
      end
      default: ;
    endcase
  end

  assign sts.last     = last_r;
  assign sts.t_zero   = (t_r == '0);
  assign sts.out_free = out_free;

  assign out_valid           = out_valid_r;
  assign out_in_phase_part   = out_ip_r;
  assign out_quadrature_part = out_qp_r;
  assign out_gain            = out_gain_r;
  assign out_phase           = out_ph_r;
  assign out_status          = out_status_r;

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.op == OP_FIN))
    else $error("result raised outside the commit step");

  a_sums_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (ssum_r == '0 && csum_r == '0 && !sat_r))
    else $error("accumulators not cleared at end of record");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_ip_r) &&
      $stable(out_qp_r) && $stable(out_gain_r) && $stable(out_ph_r) &&
      $stable(out_status_r)))
    else $error("stalled result changed");

endmodule

FILE: src/single_frequency_response_correlator_top.sv
// top level of the single frequency response correlator
// Lock-in style correlator: each item is one timed response sample; the drive phase
// phase_step*sample_time is turned into sine and cosine by an iterative CORDIC, and
// sample*sine and sample*cosine go into saturating accumulators. An ordinary item
// occupies the block through the CORDIC rotation, one iteration per cycle, and the
// shared multiply-accumulate steps. An item marked last then runs a bit-serial
// divider of DW = max(ACC_BITS, SAMPLE_BITS+31) bits for both scalings by the final
// time and for the gain, a bit-pair square root and a vectoring CORDIC pass for the
// phase; a last item with a zero final time skips these and goes straight to the
// result commit. A finished result waits in an output register; new items are taken
// meanwhile until the next last item, which waits for that register.
// Configuration writes are always ready and take effect at once.
module single_frequency_response_correlator_top #(
  parameter int SAMPLE_BITS   = sfrc_pkg::DEF_SAMPLE_BITS,
  parameter int ACC_BITS      = sfrc_pkg::DEF_ACC_BITS,
  parameter int CORDIC_STAGES = sfrc_pkg::DEF_CORDIC_STAGES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [31:0]                    in_sample_time,
  input  logic signed [SAMPLE_BITS-1:0]  in_sample_value,
  input  logic                           in_last,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [31:0]             out_in_phase_part,
  output logic signed [31:0]             out_quadrature_part,
  output logic [23:0]                    out_gain,
  output logic signed [15:0]             out_phase,
  output logic [1:0]                     out_status,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sfrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);
  import sfrc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  sfrc_ctrl #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .ACC_BITS(ACC_BITS),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts(sts),
    .cmd(cmd)
  );

  sfrc_dp #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .ACC_BITS(ACC_BITS)
  ) u_dp (
    .clk(clk),
    .rst_n(rst_n),
    .cmd(cmd),
    .sts(sts),
    .in_sample_time(in_sample_time),
    .in_sample_value(in_sample_value),
    .in_last(in_last),
    .cfg_we(cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_in_phase_part(out_in_phase_part),
    .out_quadrature_part(out_quadrature_part),
    .out_gain(out_gain),
    .out_phase(out_phase),
    .out_status(out_status)
  );

endmodule

FILE: tb/single_frequency_response_correlator_top_test.sv
// testbench of the single frequency response correlator: predicted responses checked per record
`timescale 1ns / 1ps

module single_frequency_response_correlator_top_test;
  import sfrc_pkg::*;

  localparam int STAGES = DEF_CORDIC_STAGES;
  localparam int SBITS = DEF_SAMPLE_BITS;
  localparam longint LIMIT = 64'd6000000;
  localparam int SETTLE = 400;

  typedef struct {
    logic [31:0] t;
    logic signed [15:0] v;
    logic last;
  } sample_t;

  typedef struct {
    logic signed [31:0] ip;
    logic signed [31:0] qp;
    logic [23:0] gain;
    logic signed [15:0] phase;
    logic [1:0] status;
  } response_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [31:0] in_sample_time = '0;
  logic signed [15:0] in_sample_value = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_in_phase_part;
  logic signed [31:0] out_quadrature_part;
  logic [23:0] out_gain;
  logic signed [15:0] out_phase;
  logic [1:0] out_status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_PHASE_STEP;
  logic [31:0] cfg_data = '0;

  single_frequency_response_correlator_top DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of configuration and accumulators
  logic [31:0] step_m = '0;
  logic [15:0] amp_m = 16'd1;
  longint sin_acc = 0;
  longint cos_acc = 0;
  bit acc_clamped = 1'b0;

  sample_t pending_items[$];
  response_t expected_responses[$];
  int send_idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  longint cycles = 0;

  const longint atan_tab[16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
    21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41721, 20860};

  function automatic longint round_q15(longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  function automatic void drive_sin_cos(input logic [31:0] ang, output longint s,
                                        output longint c);
    bit neg;
    longint x, y, z, xs, ys;
    neg = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
    if (neg) ang = ang - 32'h80000000;
    z = longint'($signed(ang));
    x = longint'(CORDIC_GAIN_INV);
    y = 0;
    for (int i = 0; i < STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_tab[i];
      end else begin
        x += ys; y -= xs; z += atan_tab[i];
      end
    end
    if (neg) begin
      x = -x; y = -y;
    end
    s = round_q15(y);
    c = round_q15(x);
  endfunction

  function automatic longint accum_add(longint acc, longint p);
    longint mx, mn;
    mx = (longint'(1) <<< (DEF_ACC_BITS - 1)) - 1;
    mn = -mx - 1;
    if (p > 0 && acc > mx - p) begin
      acc_clamped = 1'b1;
      return mx;
    end
    if (p < 0 && acc < mn - p) begin
      acc_clamped = 1'b1;
      return mn;
    end
    return acc + p;
  endfunction

  function automatic longint scale_by_time(longint sum, logic [63:0] d, inout bit sat);
    bit negv;
    logic [63:0] m, q;
    negv = sum < 0;
    m = negv ? -sum : sum;
    q = m / d;
    if (!negv && q > 64'd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (negv && q > 64'd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return negv ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] vector_turns(longint ip, longint qp);
    longint x, y, xs, ys;
    logic [31:0] z;
    x = ip * 65536;
    y = qp * 65536;
    z = 0;
    if (ip == 0 && qp == 0) return 0;
    if (x < 0) begin
      x = -x; y = -y; z = 32'h80000000;
    end
    for (int i = 0; i < STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += 32'(atan_tab[i]);
      end else begin
        x -= ys; y += xs; z -= 32'(atan_tab[i]);
      end
    end
    return z;
  endfunction

  // folds one sample into the sums; a last item queues the expected response
  function automatic void correlate_sample(sample_t it);
    logic [31:0] ang, zr;
    longint s, c, ip, qp;
    logic [63:0] mag, g, d;
    bit sat;
    response_t r;
    ang = step_m * it.t;
    drive_sin_cos(ang, s, c);
    sin_acc = accum_add(sin_acc, longint'(it.v) * s);
    cos_acc = accum_add(cos_acc, longint'(it.v) * c);
    if (!it.last) return;
    r = '{default: '0};
    if (it.t == 0) begin
      r.status = STATUS_TZERO;
    end else begin
      sat = acc_clamped;
      d = 64'(it.t) << (SBITS - 3);
      ip = scale_by_time(sin_acc, d, sat);
      qp = scale_by_time(cos_acc, d, sat);
      mag = int_sqrt(64'(ip * ip) + 64'(qp * qp));
      if (amp_m == 0) begin
        g = 64'hFFFFFF;
      end else begin
        g = (mag << (SBITS - 1)) / amp_m;
        if (g > 64'hFFFFFF) g = 64'hFFFFFF;
      end
      zr = vector_turns(ip, qp) + 32'h00008000;
      r.ip = ip[31:0];
      r.qp = qp[31:0];
      r.gain = g[23:0];
      r.phase = zr[31:16];
      r.status = sat ? STATUS_SAT : STATUS_OK;
    end
    expected_responses = {expected_responses, r};
    sin_acc = 0;
    cos_acc = 0;
    acc_clamped = 1'b0;
  endfunction

  // sender: holds the item until taken
  always @(posedge clk) begin
    sample_t it;
    if (rst_n && (!in_valid || !in_stall)) begin
      if (in_valid) begin
        it.t = in_sample_time;
        it.v = in_sample_value;
        it.last = in_last;
        correlate_sample(it);
      end
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        it = pending_items.pop_front();
        in_valid <= 1'b1;
        in_sample_time <= it.t;
        in_sample_value <= it.v;
        in_last <= it.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall, checks each response against the oldest prediction
  always @(posedge clk) begin
    response_t e;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("single_frequency_response_correlator_top_test failed");
      $finish;
    end else if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_responses.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("response with none expected");
        end else begin
          e = expected_responses.pop_front();
          if (out_in_phase_part !== e.ip || out_quadrature_part !== e.qp ||
              out_gain !== e.gain || out_phase !== e.phase || out_status !== e.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp ip %0d qp %0d gain %0d ph %0d st %0d, got %0d %0d %0d %0d %0d",
                       e.ip, e.qp, e.gain, e.phase, e.status, out_in_phase_part,
                       out_quadrature_part, out_gain, out_phase, out_status);
          end
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid || expected_responses.size() > 0)
      @(posedge clk);
    // a trailing record without last may still be in the datapath
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_PHASE_STEP) step_m = val;
    else amp_m = val[15:0];
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void add_item(logic [31:0] t, logic [15:0] v, logic last);
    sample_t it;
    it.t = t;
    it.v = v;
    it.last = last;
    pending_items = {pending_items, it};
  endfunction

  function automatic logic [15:0] rand_value();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // records with growing times, random lengths and occasional odd times
  task automatic random_records(int count);
    int n, len;
    logic [31:0] t;
    n = 0;
    while (n < count) begin
      len = $urandom_range(1, 8);
      t = ($urandom_range(3) == 0) ? $urandom : $urandom_range(200);
      for (int k = 0; k < len; k++) begin
        if (k == len - 1 && $urandom_range(19) == 0) t = 0;
        add_item(t, rand_value(), k == len - 1);
        t = t + $urandom_range(1, 1000);
        n++;
      end
    end
  endtask

  task automatic random_config();
    case ($urandom_range(5))
      0: write_reg(CFG_PHASE_STEP, 32'h0);
      1: write_reg(CFG_PHASE_STEP, 32'hFFFFFFFF);
      default: write_reg(CFG_PHASE_STEP, $urandom);
    endcase
    case ($urandom_range(4))
      0: write_reg(CFG_DRIVE_AMP, 32'd1);
      1: write_reg(CFG_DRIVE_AMP, 32'd65535);
      default: write_reg(CFG_DRIVE_AMP, $urandom_range(1, 65535));
    endcase
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(CFG_PHASE_STEP, 32'h40000000);
    write_reg(CFG_DRIVE_AMP, 32'd1);
    add_item(32'd0, 16'h7FFF, 1'b1);           // final time zero
    add_item(32'd1, 16'h8000, 1'b0);
    add_item(32'd2, 16'h7FFF, 1'b0);
    add_item(32'hFFFFFFFF, 16'h1234, 1'b1);
    add_item(32'd1, 16'h7FFF, 1'b1);           // gain clamps at full scale
    add_item(32'd5, 16'h0000, 1'b1);           // zero vector
    wait_drained();
    write_reg(CFG_DRIVE_AMP, 32'd0);
    add_item(32'd3, 16'h8000, 1'b1);
    wait_drained();
    write_reg(CFG_DRIVE_AMP, 32'd65535);
    write_reg(CFG_PHASE_STEP, 32'hFFFFFFFF);
    add_item(32'd7, 16'h4000, 1'b0);
    add_item(32'd9, 16'h8000, 1'b1);
    wait_drained();

    // record at zero frequency builds large sums of one sign
    write_reg(CFG_PHASE_STEP, 32'h0);
    for (int k = 0; k < 30; k++) add_item(32'd0, 16'h8000, 1'b0);
    add_item(32'd1, 16'h8000, 1'b1);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 81; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 81; end
        default: begin send_idle_pct = 30; stall_pct = 30; end
      endcase
      random_config();
      random_records(76);
      wait_drained();
    end

    if (mismatches == 0 && expected_responses.size() == 0) begin
      $display("single_frequency_response_correlator_top_test passed");
    end else begin
      $display("single_frequency_response_correlator_top_test failed");
    end
    $finish;
  end

endmodule
